// ===== rtl/q4k_pkg.sv =====
// Q4_K dequantizer package: command word type, stream constants and fp16 helpers.
package q4k_pkg;

   // Super-block layout
   localparam logic [7:0] BLOCK_BYTES   = 8'd144;
   localparam logic [7:0] SCALES_START  = 8'd4;
   localparam logic [7:0] NIBBLES_START = 8'd16;

   // Default NaN as produced for invalid operations
   localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;

   // One dequantization job handed from the front to the back
   typedef struct packed {
      logic [15:0] d;
      logic [15:0] dm;
      logic [5:0]  sc;
      logic [5:0]  mn;
      logic [3:0]  q;
      logic        last;
      logic        blk_end;
   } cmd_type;

   // Significand of an fp16 value, hidden bit included
   function automatic logic [10:0] half_sig(input logic [15:0] h);
      half_sig = (h[14:10] == 5'd0) ? {1'b0, h[9:0]} : {1'b1, h[9:0]};
   endfunction

   // Left shift that places the significand on a 2^-24 grid
   function automatic logic [4:0] half_shift(input logic [15:0] h);
      half_shift = (h[14:10] == 5'd0) ? 5'd0 : h[14:10] - 5'd1;
   endfunction

   function automatic logic half_inf(input logic [15:0] h);
      half_inf = (h[14:10] == 5'h1F) && (h[9:0] == 10'd0);
   endfunction

   function automatic logic half_nan(input logic [15:0] h);
      half_nan = (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
   endfunction

   // fp16 NaN widened to binary32 and quietened
   function automatic logic [31:0] half_qnan(input logic [15:0] h);
      half_qnan = {h[15], 8'hFF, 1'b1, h[8:0], 13'd0};
   endfunction

endpackage

// ===== rtl/q4k_front.sv =====
// Q4_K front end: byte position tracking, header capture and job issue.
module q4k_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               queue_full,
   output logic               push,
   output q4k_pkg::cmd_type   cmd
);

   logic [7:0]  pos_ff;
   logic [15:0] d_ff;
   logic [15:0] dm_ff;
   logic [7:0]  scales_ff [12];
   logic [3:0]  pend_ff [32];
   logic        burst_ff;
   logic [4:0]  hcnt_ff;
   logic [1:0]  grp_ff;

   logic        accept;
   logic        nib_byte;
   logic [7:0]  rel;
   logic [7:0]  scl_off;
   logic [7:0]  pos_in;
   logic [2:0]  sub_j;
   logic [3:0]  j4;
   logic [5:0]  sc;
   logic [5:0]  mn;

   assign req_stall = burst_ff | queue_full;
   assign accept    = req_valid & ~req_stall;
   assign nib_byte  = (pos_ff >= q4k_pkg::NIBBLES_START);
   assign rel       = pos_ff - q4k_pkg::NIBBLES_START;
   assign scl_off   = pos_ff - q4k_pkg::SCALES_START;
   assign pos_in    = (pos_ff == q4k_pkg::BLOCK_BYTES - 8'd1) ? 8'd0 : pos_ff + 8'd1;

   // sub-block: low nibbles of group g are 2g, the high-nibble run is 2g+1
   assign sub_j = burst_ff ? {grp_ff, 1'b1} : {rel[6:5], 1'b0};
   assign j4    = {1'b0, sub_j};

   // unpack the 6-bit scale and min
   always_comb begin
      if (sub_j[2] == 1'b0) begin
         sc = scales_ff[j4][5:0];
         mn = scales_ff[j4 + 4'd4][5:0];
      end else begin
         sc = {scales_ff[j4 - 4'd4][7:6], scales_ff[j4 + 4'd4][3:0]};
         mn = {scales_ff[j4][7:6], scales_ff[j4 + 4'd4][7:4]};
      end
   end

   // job word
   always_comb begin
      cmd.d       = d_ff;
      cmd.dm      = dm_ff;
      cmd.sc      = sc;
      cmd.mn      = mn;
      if (burst_ff) begin
         cmd.q       = pend_ff[hcnt_ff];
         cmd.last    = (hcnt_ff == 5'd31);
         cmd.blk_end = (hcnt_ff == 5'd31) && (grp_ff == 2'd3);
      end else begin
         cmd.q       = req_data_byte[3:0];
         cmd.last    = (rel[4:0] != 5'd31);
         cmd.blk_end = 1'b0;
      end
      push = burst_ff ? ~queue_full : (accept & nib_byte);
   end

   // position, header stores and high-nibble run control
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 8'd0;
         d_ff     <= 16'd0;
         dm_ff    <= 16'd0;
         burst_ff <= 1'b0;
         hcnt_ff  <= 5'd0;
         grp_ff   <= 2'd0;
      end else begin
         if (accept) begin
            pos_ff <= pos_in;
            if (pos_ff == 8'd0) d_ff[7:0]   <= req_data_byte;
            if (pos_ff == 8'd1) d_ff[15:8]  <= req_data_byte;
            if (pos_ff == 8'd2) dm_ff[7:0]  <= req_data_byte;
            if (pos_ff == 8'd3) dm_ff[15:8] <= req_data_byte;
            if (nib_byte && rel[4:0] == 5'd31) begin
               burst_ff <= 1'b1;
               grp_ff   <= rel[6:5];
               hcnt_ff  <= 5'd0;
            end
         end else if (burst_ff && !queue_full) begin
            hcnt_ff <= hcnt_ff + 5'd1;
            if (hcnt_ff == 5'd31) burst_ff <= 1'b0;
         end
      end
   end

   // payload stores, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         if (nib_byte) pend_ff[rel[4:0]] <= req_data_byte[7:4];
         else if (pos_ff >= q4k_pkg::SCALES_START) scales_ff[scl_off[3:0]] <= req_data_byte;
      end
   end

endmodule

// ===== rtl/q4k_fifo.sv =====
// Q4_K job queue between front and back, four entries.
module q4k_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  q4k_pkg::cmd_type   push_cmd,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output q4k_pkg::cmd_type   pop_cmd
);

   q4k_pkg::cmd_type mem_ff [4];
   logic [1:0] wptr_ff;
   logic [1:0] rptr_ff;
   logic [2:0] count_ff;

   assign full      = (count_ff == 3'd4);
   assign not_empty = (count_ff != 3'd0);
   assign pop_cmd   = mem_ff[rptr_ff];

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 2'd0;
         rptr_ff  <= 2'd0;
         count_ff <= 3'd0;
      end else begin
         if (push) wptr_ff <= wptr_ff + 2'd1;
         if (pop)  rptr_ff <= rptr_ff + 2'd1;
         count_ff <= count_ff + {2'd0, push} - {2'd0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= push_cmd;
   end

endmodule

// ===== rtl/q4k_back.sv =====
// Q4_K back end: exact fixed-point products, subtract and binary32 rounding.
module q4k_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  q4k_pkg::cmd_type   in_cmd,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_value,
   output logic               rsp_last_in_run,
   output logic               rsp_block_end
);

   logic en;
   logic v1_ff, v2_ff, v3_ff, v4_ff, out_v_ff;

   // stage 1
   logic [16:0] pd1_ff, pm1_ff;
   logic [4:0]  shd1_ff, shm1_ff;
   logic [3:0]  q1_ff;
   logic        sx1_ff, sy1_ff, spec1_ff, last1_ff, end1_ff;
   logic [31:0] sbits1_ff;
   // stage 2
   logic [49:0] a2_ff, b2_ff;
   logic        sx2_ff, sy2_ff, spec2_ff, last2_ff, end2_ff;
   logic [31:0] sbits2_ff;
   // stage 3
   logic [50:0] mag3_ff;
   logic        sg3_ff, spec3_ff, last3_ff, end3_ff;
   logic [31:0] sbits3_ff;
   // stage 4
   logic [50:0] mag4_ff;
   logic [5:0]  lead4_ff;
   logic        zero4_ff, sg4_ff, spec4_ff, last4_ff, end4_ff;
   logic [31:0] sbits4_ff;
   // output word
   logic [31:0] value_ff;
   logic        last_ff, end_ff;

   logic        t3_nan, t3_inf, t2_nan, t2_inf, spec_in;
   logic [31:0] t3_bits, t2_bits, sbits_in;
   logic [20:0] pq;
   logic [50:0] mag_in;
   logic        sg_in;
   logic [5:0]  lead_in;
   logic [50:0] norm;
   logic        round_up;
   logic [30:0] body;
   logic [31:0] value_in;

   assign en  = ~out_v_ff | ~rsp_stall;
   assign pop = en & in_valid;

   // special operands: t3 = d*sc*q, t2 = dmin*m
   always_comb begin
      t3_nan  = 1'b0;
      t3_inf  = 1'b0;
      t3_bits = q4k_pkg::DEFAULT_NAN;
      if (q4k_pkg::half_nan(in_cmd.d)) begin
         t3_nan  = 1'b1;
         t3_bits = q4k_pkg::half_qnan(in_cmd.d);
      end else if (q4k_pkg::half_inf(in_cmd.d)) begin
         if (in_cmd.sc == 6'd0 || in_cmd.q == 4'd0) begin
            t3_nan = 1'b1;
         end else begin
            t3_inf  = 1'b1;
            t3_bits = {in_cmd.d[15], 8'hFF, 23'd0};
         end
      end
      t2_nan  = 1'b0;
      t2_inf  = 1'b0;
      t2_bits = q4k_pkg::DEFAULT_NAN;
      if (q4k_pkg::half_nan(in_cmd.dm)) begin
         t2_nan  = 1'b1;
         t2_bits = q4k_pkg::half_qnan(in_cmd.dm);
      end else if (q4k_pkg::half_inf(in_cmd.dm)) begin
         if (in_cmd.mn == 6'd0) begin
            t2_nan = 1'b1;
         end else begin
            t2_inf  = 1'b1;
            t2_bits = {in_cmd.dm[15], 8'hFF, 23'd0};
         end
      end
      // resolve t3 - t2
      spec_in  = 1'b1;
      sbits_in = q4k_pkg::DEFAULT_NAN;
      if (t3_nan)                        sbits_in = t3_bits;
      else if (t2_nan)                   sbits_in = t2_bits;
      else if (t3_inf && t2_inf)         sbits_in = (t3_bits[31] == t2_bits[31]) ?
                                                    q4k_pkg::DEFAULT_NAN : t3_bits;
      else if (t3_inf)                   sbits_in = t3_bits;
      else if (t2_inf)                   sbits_in = {~t2_bits[31], t2_bits[30:0]};
      else                               spec_in  = 1'b0;
   end

   // exact difference of the two signed magnitudes
   always_comb begin
      if (sx2_ff == sy2_ff) begin
         mag_in = {1'b0, a2_ff} + {1'b0, b2_ff};
         sg_in  = sx2_ff;
      end else if (a2_ff >= b2_ff) begin
         mag_in = {1'b0, a2_ff - b2_ff};
         sg_in  = sx2_ff;
      end else begin
         mag_in = {1'b0, b2_ff - a2_ff};
         sg_in  = sy2_ff;
      end
      if (mag_in == 51'd0 && sx2_ff != sy2_ff) sg_in = 1'b0;
   end

   // leading one position
   always_comb begin
      lead_in = 6'd0;
      for (int i = 0; i < 51; i++) begin
         if (mag3_ff[i]) lead_in = 6'(i);
      end
   end

   assign pq = pd1_ff * q1_ff;

   // normalise and round to nearest even
   always_comb begin
      norm     = mag4_ff << (6'd50 - lead4_ff);
      round_up = norm[26] & ((|norm[25:0]) | norm[27]);
      body     = {8'(lead4_ff) + 8'd103, norm[49:27]} + {30'd0, round_up};
      if (spec4_ff)      value_in = sbits4_ff;
      else if (zero4_ff) value_in = {sg4_ff, 31'd0};
      else               value_in = {sg4_ff, body};
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         v1_ff    <= in_valid;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         v4_ff    <= v3_ff;
         out_v_ff <= v4_ff;
      end
   end

   // datapath stages
   always_ff @(posedge clock) begin
      if (en) begin
         pd1_ff    <= q4k_pkg::half_sig(in_cmd.d) * in_cmd.sc;
         pm1_ff    <= q4k_pkg::half_sig(in_cmd.dm) * in_cmd.mn;
         shd1_ff   <= q4k_pkg::half_shift(in_cmd.d);
         shm1_ff   <= q4k_pkg::half_shift(in_cmd.dm);
         q1_ff     <= in_cmd.q;
         sx1_ff    <= in_cmd.d[15];
         sy1_ff    <= ~in_cmd.dm[15];
         spec1_ff  <= spec_in;
         sbits1_ff <= sbits_in;
         last1_ff  <= in_cmd.last;
         end1_ff   <= in_cmd.blk_end;

         a2_ff     <= {29'd0, pq} << shd1_ff;
         b2_ff     <= {33'd0, pm1_ff} << shm1_ff;
         sx2_ff    <= sx1_ff;
         sy2_ff    <= sy1_ff;
         spec2_ff  <= spec1_ff;
         sbits2_ff <= sbits1_ff;
         last2_ff  <= last1_ff;
         end2_ff   <= end1_ff;

         mag3_ff   <= mag_in;
         sg3_ff    <= sg_in;
         spec3_ff  <= spec2_ff;
         sbits3_ff <= sbits2_ff;
         last3_ff  <= last2_ff;
         end3_ff   <= end2_ff;

         mag4_ff   <= mag3_ff;
         lead4_ff  <= lead_in;
         zero4_ff  <= (mag3_ff == 51'd0);
         sg4_ff    <= sg3_ff;
         spec4_ff  <= spec3_ff;
         sbits4_ff <= sbits3_ff;
         last4_ff  <= last3_ff;
         end4_ff   <= end3_ff;

         value_ff  <= value_in;
         last_ff   <= last4_ff;
         end_ff    <= end4_ff;
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_value       = value_ff;
   assign rsp_last_in_run = last_ff;
   assign rsp_block_end   = end_ff;

endmodule

// ===== rtl/q4k_block_dequantizer.sv =====
// Q4_K block dequantizer top level: front end, job queue and arithmetic back end.
//
//   channel | ports              | direction | word
//   req     | req_valid/_stall   | in        | one raw super-block byte
//   rsp     | rsp_valid/_stall   | out       | binary32 value, run and block flags
//
// Header bytes (16 per super-block) give no word.
// A nibble byte gives one word; after the 32nd byte of a group the input
// is held while the 32 kept high nibbles are issued.
// Queue entry, four back-end stages and the output register lie between
// an accepted byte and its word.
// Synchronous reset clears position, queue and pipeline valids.
// A stalled word freezes the whole back end; a full queue stalls the input.
module q4k_block_dequantizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_value,
   output logic        rsp_last_in_run,
   output logic        rsp_block_end
);

   q4k_pkg::cmd_type push_cmd;
   q4k_pkg::cmd_type pop_cmd;
   logic push, full, pop, not_empty;

   q4k_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .queue_full    (full),
      .push          (push),
      .cmd           (push_cmd)
   );

   q4k_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_cmd   (pop_cmd)
   );

   q4k_back u_back (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (not_empty),
      .in_cmd          (pop_cmd),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value       (rsp_value),
      .rsp_last_in_run (rsp_last_in_run),
      .rsp_block_end   (rsp_block_end)
   );

endmodule

// ===== rtl/q4k_checker.sv =====
// Q4_K port checker and its bind to the top level.
module q4k_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_data_byte,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_value,
   input logic        rsp_last_in_run,
   input logic        rsp_block_end
);

   // block end only closes a run
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_block_end |-> rsp_last_in_run)
      else $error("block_end without last_in_run");

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value))
      else $error("stalled word changed");

   // a stalled input byte holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data_byte))
      else $error("stalled input byte changed");

   // no word straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("word shown after reset");

   // block ends never come back to back
   a_run_then_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_block_end |=> !(rsp_valid && rsp_block_end))
      else $error("two block ends in a row");

endmodule

bind q4k_block_dequantizer q4k_checker u_q4k_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_data_byte   (req_data_byte),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_value       (rsp_value),
   .rsp_last_in_run (rsp_last_in_run),
   .rsp_block_end   (rsp_block_end)
);

// ===== verif/testbench.sv =====
// Self-checking testbench for q4k_block_dequantizer: random super-blocks, bit-exact scoreboard.
`timescale 1ns / 100ps

module testbench;

   localparam int          GROUP_BYTES = 32;
   localparam int          RUN_LIMIT   = 400000;
   localparam bit [31:0]   QUIET_BIT   = 32'h0040_0000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_value;
   logic        rsp_last_in_run;
   logic        rsp_block_end;

   int  cycle_count = 0;
   bit  calm = 1'b0;

   q4k_block_dequantizer dut (.*);

   always #4 clock = ~clock;

   // ---- binary32 arithmetic, round to nearest even ----

   function automatic bit is_nan(bit [31:0] x);
      return x[30:23] == 8'hFF && x[22:0] != 0;
   endfunction

   function automatic bit is_inf(bit [31:0] x);
      return x[30:23] == 8'hFF && x[22:0] == 0;
   endfunction

   // value = m * 2^e (plus a sticky remainder below m's lsb), rounded to binary32
   function automatic bit [31:0] round_pack(bit s, bit [127:0] m, int e, bit st);
      int         p, ex, sh;
      bit [127:0] kept;
      bit         g, rs;
      bit [31:0]  r;
      if (m == 0) return {s, 31'd0};
      p = 127;
      while (!m[p]) p--;
      ex = p + e;
      if (ex > 127) return {s, 8'hFF, 23'd0};
      if (ex < -126) ex = -126;
      sh = (ex - 23) - e;
      if (sh <= 0) begin
         kept = m << (-sh);
         g    = 1'b0;
         rs   = st;
      end else if (sh >= 128) begin
         kept = 0;
         g    = 1'b0;
         rs   = 1'b1;
      end else begin
         kept = m >> sh;
         g    = m[sh-1];
         rs   = st | ((m & ((128'd1 << (sh - 1)) - 1)) != 0);
      end
      // hidden bit carries into the exponent field; subnormals fall out at ex = -126
      r = (32'(ex + 126) << 23) + kept[31:0];
      if (g && (rs || kept[0])) r++;
      return {s, r[30:0]};
   endfunction

   function automatic void unpack_f(bit [31:0] f, output bit [127:0] sig, output int e);
      if (f[30:23] == 0) begin
         sig = 128'(f[22:0]);
         e   = -149;
      end else begin
         sig = 128'({1'b1, f[22:0]});
         e   = int'(f[30:23]) - 150;
      end
   endfunction

   function automatic bit [31:0] fp_mul(bit [31:0] a, bit [31:0] b);
      bit [127:0] sa, sb;
      int         ea, eb;
      if (is_nan(a)) return a | QUIET_BIT;
      if (is_nan(b)) return b | QUIET_BIT;
      if (is_inf(a) || is_inf(b)) begin
         if (a[30:0] == 0 || b[30:0] == 0) return q4k_pkg::DEFAULT_NAN;
         return {a[31] ^ b[31], 8'hFF, 23'd0};
      end
      unpack_f(a, sa, ea);
      unpack_f(b, sb, eb);
      return round_pack(a[31] ^ b[31], sa * sb, ea + eb, 1'b0);
   endfunction

   function automatic bit [31:0] fp_add(bit [31:0] a, bit [31:0] b);
      bit [127:0] sa, sb, ma, mb, m;
      int         ea, eb, d;
      bit         xa, xb, s;
      bit [31:0]  t;
      if (is_nan(a)) return a | QUIET_BIT;
      if (is_nan(b)) return b | QUIET_BIT;
      if (is_inf(a) && is_inf(b)) return (a[31] != b[31]) ? q4k_pkg::DEFAULT_NAN : a;
      if (is_inf(a)) return a;
      if (is_inf(b)) return b;
      if (b[30:0] == 0 && a[30:0] != 0) return a;
      if (a[30:0] == 0 && b[30:0] != 0) return b;
      unpack_f(a, sa, ea);
      unpack_f(b, sb, eb);
      xa = a[31];
      xb = b[31];
      if (eb > ea) begin
         m = sa; sa = sb; sb = m;
         d = ea; ea = eb; eb = d;
         s = xa; xa = xb; xb = s;
      end
      d = ea - eb;
      // far smaller operand only nudges the rounding
      if (d > 100)
         return round_pack(xa, (xa == xb) ? (sa << 3) : ((sa << 3) - 1), ea - 3, 1'b1);
      ma = sa << d;
      mb = sb;
      if (xa == xb) begin
         m = ma + mb; s = xa;
      end else if (ma >= mb) begin
         m = ma - mb; s = xa;
      end else begin
         m = mb - ma; s = xb;
      end
      if (m == 0) s = xa & xb;
      t = round_pack(s, m, eb, 1'b0);
      return t;
   endfunction

   function automatic bit [31:0] fp_sub(bit [31:0] a, bit [31:0] b);
      if (is_nan(a)) return a | QUIET_BIT;
      if (is_nan(b)) return b | QUIET_BIT;
      return fp_add(a, {~b[31], b[30:0]});
   endfunction

   function automatic bit [31:0] int_to_fp(int n);
      return round_pack(1'b0, 128'(n), 0, 1'b0);
   endfunction

   // fp16 bits widened to binary32; NaN payload carried over unquietened
   function automatic bit [31:0] half_to_fp(bit [15:0] h);
      bit [31:0] sign;
      int        ex;
      bit [10:0] man;
      sign = {h[15], 31'd0};
      ex   = int'(h[14:10]);
      man  = {1'b0, h[9:0]};
      if (ex == 0) begin
         if (man == 0) return sign;
         ex = 127 - 15 + 1;
         while (!man[10]) begin
            man = man << 1;
            ex--;
         end
         return sign | (32'(ex) << 23) | (32'(man[9:0]) << 13);
      end
      if (ex == 31) return sign | 32'h7F80_0000 | (32'(man[9:0]) << 13);
      return sign | (32'(ex - 15 + 127) << 23) | (32'(man[9:0]) << 13);
   endfunction

   // ---- scoreboard: stream predictor plus queue of expected words ----
   class q4k_scoreboard;
      int         position;
      bit [15:0]  blk_scale, blk_min;
      bit [7:0]   scale_bytes [12];
      bit [3:0]   high_nibbles [GROUP_BYTES];
      bit [31:0]  want_value [$];
      bit         want_last [$];
      bit         want_end [$];
      int         mismatches;

      function void split_scale_min(int sub, output int sc, output int mn);
         int j;
         j = sub & 7;
         if (j < 4) begin
            sc = scale_bytes[j] & 63;
            mn = scale_bytes[j+4] & 63;
         end else begin
            sc = (scale_bytes[j+4] & 4'hF) | ((scale_bytes[j-4] >> 6) << 4);
            mn = (scale_bytes[j+4] >> 4) | ((scale_bytes[j] >> 6) << 4);
         end
      endfunction

      function bit [31:0] weight(int sub, bit [3:0] q);
         int        sc, mn;
         bit [31:0] t1, t2, t3;
         split_scale_min(sub, sc, mn);
         t1 = fp_mul(half_to_fp(blk_scale), int_to_fp(sc));
         t2 = fp_mul(half_to_fp(blk_min), int_to_fp(mn));
         t3 = fp_mul(t1, int_to_fp(q));
         return fp_sub(t3, t2);
      endfunction

      function void push(bit [31:0] v, bit l, bit e);
         want_value.push_back(v);
         want_last.push_back(l);
         want_end.push_back(e);
      endfunction

      // accepted input byte: advance the stream and queue what it yields
      function void note_byte(bit [7:0] b);
         int grp, idx;
         if (position == 0)      blk_scale[7:0]  = b;
         else if (position == 1) blk_scale[15:8] = b;
         else if (position == 2) blk_min[7:0]    = b;
         else if (position == 3) blk_min[15:8]   = b;
         else if (position < q4k_pkg::NIBBLES_START)
            scale_bytes[position - q4k_pkg::SCALES_START] = b;
         else begin
            grp = (position - q4k_pkg::NIBBLES_START) / GROUP_BYTES;
            idx = (position - q4k_pkg::NIBBLES_START) % GROUP_BYTES;
            high_nibbles[idx] = b[7:4];
            push(weight(2 * grp, b[3:0]), idx != GROUP_BYTES - 1, 1'b0);
            if (idx == GROUP_BYTES - 1)
               for (int l = 0; l < GROUP_BYTES; l++)
                  push(weight(2 * grp + 1, high_nibbles[l]), l == GROUP_BYTES - 1,
                       l == GROUP_BYTES - 1 && grp == 3);
         end
         position = (position + 1) % q4k_pkg::BLOCK_BYTES;
      endfunction

      function void check_word(bit [31:0] v, bit l, bit e);
         bit [31:0] xv;
         bit        xl, xe;
         if (want_value.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: value %h last %b end %b", v, l, e);
            return;
         end
         xv = want_value.pop_front();
         xl = want_last.pop_front();
         xe = want_end.pop_front();
         if (v !== xv || l !== xl || e !== xe) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %h/%b/%b, got %h/%b/%b", xv, xl, xe, v, l, e);
         end
      endfunction

      function int pending();
         return want_value.size();
      endfunction
   endclass

   q4k_scoreboard sb = new;

   // cycle counter and run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("q4k_block_dequantizer regression: fail");
         $finish;
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_word(rsp_value, rsp_last_in_run, rsp_block_end);
   end

   // receiver stalls: a random hold-off before each word
   initial begin
      int n;
      @(negedge reset);
      forever begin
         n = calm ? 0 : $urandom_range(0, 10);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // one byte: optional gap, then hold until accepted
   task automatic send_byte(bit [7:0] b);
      int n;
      n = calm ? 0 : $urandom_range(0, 10);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      sb.note_byte(b);
   endtask

   // one super-block; pattern 0 random nibbles, 1 nibble extremes, 2 saturated scales
   // nib_bytes below 128 cuts the block short after that many nibble bytes
   task automatic send_block(bit [15:0] d, bit [15:0] dm, int pattern, int nib_bytes = 128);
      bit [7:0] b;
      send_byte(d[7:0]);
      send_byte(d[15:8]);
      send_byte(dm[7:0]);
      send_byte(dm[15:8]);
      for (int i = 0; i < 12; i++)
         send_byte(pattern == 2 ? 8'hFF : 8'($urandom));
      for (int i = 0; i < nib_bytes; i++) begin
         case (pattern)
            1:       b = (i % 4 == 0) ? 8'h00 : (i % 4 == 1) ? 8'hFF :
                         (i % 4 == 2) ? 8'h0F : 8'hF0;
            default: b = 8'($urandom);
         endcase
         send_byte(b);
      end
   endtask

   function automatic bit [15:0] pick_half();
      case ($urandom_range(0, 9))
         0:       return 16'h0001;
         1:       return 16'h7BFF;
         2:       return 16'h8400;
         3:       return 16'h0000;
         4:       return 16'h03FF;
         default: return 16'($urandom);
      endcase
   endfunction

   // main sequence
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // infinities: inf*0 gives the default NaN, and +inf minus -inf gives +inf
      send_block(16'h7C00, 16'hFC00, 1);
      // NaN operands, and largest scale against smallest subnormal min
      send_block(16'h7E01, 16'hFD55, 2);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      send_block(16'h7BFF, 16'h0001, 1);

      // short tail: header and one group, possibly back to back
      calm = ($urandom_range(0, 1) == 1);
      send_block(pick_half(), pick_half(), $urandom_range(0, 3) == 0 ? 2 : 0, GROUP_BYTES);
      calm = 1'b0;
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("q4k_block_dequantizer regression: pass");
      else
         $display("q4k_block_dequantizer regression: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/q4k_pkg.sv
rtl/q4k_front.sv
rtl/q4k_fifo.sv
rtl/q4k_back.sv
rtl/q4k_block_dequantizer.sv
rtl/q4k_checker.sv
verif/testbench.sv
